@@ hw/rtl/nhm_pkg.sv @@
// shared constants, types and helpers for the mersenne-61 numeric hash
`timescale 1ns / 1ps
`default_nettype none
package nhm_pkg;

    typedef logic [63:0] t_word;
    typedef logic [60:0] t_res61;

    // op codes
    localparam logic OP_INT   = 1'b0;
    localparam logic OP_FLOAT = 1'b1;

    localparam t_res61 MODP          = 61'h1FFF_FFFF_FFFF_FFFF;
    localparam t_word  MIN_INT       = 64'h8000_0000_0000_0000;
    localparam t_word  MIN_INT_HASH  = 64'hFFFF_FFFF_FFFF_FFFC;   // -4
    localparam t_word  MINUS_ONE     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam t_word  MINUS_TWO     = 64'hFFFF_FFFF_FFFF_FFFE;
    localparam t_word  INF_HASH      = 64'd314159;
    localparam logic [10:0] EXP_SPECIAL = 11'h7FF;
    localparam logic [10:0] EXP_ZERO    = 11'h000;
    // exponent bias 1075 folded mod 61: (expo - 1075) mod 61 == (expo + 23) mod 61
    localparam logic [11:0] EXP_ROT_OFS = 12'd23;
    localparam logic [7:0]  ROT_MOD     = 8'd61;
    localparam logic [7:0]  ROT_MOD_X2  = 8'd122;

    function automatic t_word fix_minus_one(input t_word h);
        fix_minus_one = (h == MINUS_ONE) ? MINUS_TWO : h;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/numeric_hash_mersenne61.sv @@
// a word accepted with start is held in the input registers, and its hash in the result register that drives o_valid
// throughput: one word per cycle, busy never rises; set by the single hash pass
// between the input register and the result register
// reset: synchronous, active low; clears the valid flags, so no results are invented
// the receiver cannot stall: each hash stands on the outputs for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none
module numeric_hash_mersenne61 (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_op,
    input  wire logic signed [63:0] i_int_value,
    input  wire logic [63:0]        i_float_bits,
    input  wire logic [63:0]        i_object_address,
    output logic                    o_valid,
    output logic signed [63:0]      o_hash_value
);
    logic                 r_in_valid;
    logic                 r_op;
    logic signed [63:0]   r_int_value;
    nhm_pkg::t_word       r_float_bits;
    nhm_pkg::t_word       r_object_address;
    logic                 r_out_valid;
    nhm_pkg::t_word       r_hash;

    nhm_pkg::t_word       int_hash;
    nhm_pkg::t_word       float_hash;
    nhm_pkg::t_word       n_hash;

    nhm_int_hash u_int (
        .i_value (r_int_value),
        .o_hash  (int_hash)
    );

    nhm_float_hash u_float (
        .i_bits (r_float_bits),
        .i_addr (r_object_address),
        .o_hash (float_hash)
    );

    assign busy   = 1'b0;
    assign n_hash = (r_op == nhm_pkg::OP_FLOAT) ? float_hash : int_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
        r_op             <= i_op;
        r_int_value      <= i_int_value;
        r_float_bits     <= i_float_bits;
        r_object_address <= i_object_address;
        r_hash           <= n_hash;
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_hash;
endmodule
`default_nettype wire

@@ hw/rtl/nhm_int_hash.sv @@
// integer hash: signed value reduced modulo 2^61-1
`timescale 1ns / 1ps
`default_nettype none
module nhm_int_hash (
    input  wire logic signed [63:0] i_value,
    output nhm_pkg::t_word          o_hash
);
    logic                neg;
    logic [63:0]         mag;
    logic [61:0]         fold;
    nhm_pkg::t_res61     red;
    nhm_pkg::t_word      ext;
    nhm_pkg::t_word      signed_red;

    always_comb begin
        neg  = i_value[63];
        mag  = neg ? (64'd0 - i_value) : i_value;
        // 2^61 == 1 mod p, so the top bits fold straight onto the low 61
        fold = {1'b0, mag[60:0]} + {60'd0, mag[62:61]};
        red  = (fold >= {1'b0, nhm_pkg::MODP}) ? 61'(fold - {1'b0, nhm_pkg::MODP})
                                               : fold[60:0];
        ext  = {3'b000, red};
        signed_red = neg ? (64'd0 - ext) : ext;
        if (i_value == nhm_pkg::MIN_INT) begin
            o_hash = nhm_pkg::MIN_INT_HASH;
        end else begin
            o_hash = nhm_pkg::fix_minus_one(signed_red);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/nhm_float_hash.sv @@
// float hash: mantissa rotated within 61 bits by exponent mod 61, then signed
`timescale 1ns / 1ps
`default_nettype none
module nhm_float_hash (
    input  wire nhm_pkg::t_word i_bits,
    input  wire nhm_pkg::t_word i_addr,
    output nhm_pkg::t_word      o_hash
);
    logic            neg;
    logic [10:0]     expo;
    logic [51:0]     frac;
    logic [10:0]     expo_eff;
    logic [11:0]     rot_sum;
    logic [7:0]      rot_fold;
    logic [5:0]      rot;
    nhm_pkg::t_res61 mant;
    logic [121:0]    dbl;
    nhm_pkg::t_res61 rotl;
    nhm_pkg::t_word  ext;
    nhm_pkg::t_word  finite;
    nhm_pkg::t_word  nan_hash;

    always_comb begin
        neg  = i_bits[63];
        expo = i_bits[62:52];
        frac = i_bits[51:0];
        // subnormals share exponent -1074 with the smallest normal
        expo_eff = (expo == nhm_pkg::EXP_ZERO) ? 11'd1 : expo;
        rot_sum  = {1'b0, expo_eff} + nhm_pkg::EXP_ROT_OFS;
        // 64 == 3 mod 61
        rot_fold = 8'({2'b00, rot_sum[11:6]} * 8'd3) + {2'b00, rot_sum[5:0]};
        if (rot_fold >= nhm_pkg::ROT_MOD_X2) begin
            rot = 6'(rot_fold - nhm_pkg::ROT_MOD_X2);
        end else if (rot_fold >= nhm_pkg::ROT_MOD) begin
            rot = 6'(rot_fold - nhm_pkg::ROT_MOD);
        end else begin
            rot = rot_fold[5:0];
        end
        mant = {8'd0, (expo != nhm_pkg::EXP_ZERO), frac};
        dbl  = {mant, mant} << rot;
        rotl = dbl[121:61];
        ext  = {3'b000, rotl};
        finite   = nhm_pkg::fix_minus_one(neg ? (64'd0 - ext) : ext);
        nan_hash = nhm_pkg::fix_minus_one({i_addr[3:0], i_addr[63:4]});

        if (expo == nhm_pkg::EXP_SPECIAL) begin
            if (frac == 52'd0) begin
                o_hash = neg ? (64'd0 - nhm_pkg::INF_HASH) : nhm_pkg::INF_HASH;
            end else begin
                o_hash = nan_hash;
            end
        end else if (expo == nhm_pkg::EXP_ZERO && frac == 52'd0) begin
            o_hash = '0;
        end else begin
            o_hash = finite;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/nhm_chk.sv @@
// port-level checker for the numeric hash, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module nhm_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               i_op,
    input wire logic signed [63:0] i_int_value,
    input wire logic               o_valid,
    input wire logic signed [63:0] o_hash_value
);
    // every accepted word comes back as a result on o_valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted word gave no result");

    // no result without a word behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without an accepted word");

    a_never_minus_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hash_value != 64'hFFFF_FFFF_FFFF_FFFF))
        else $error("hash of minus one shown");

    // integer zero hashes to zero
    a_int_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == nhm_pkg::OP_INT && i_int_value == 64'sd0)
            |=> ##1 (o_valid && o_hash_value == 64'sd0))
        else $error("integer zero did not hash to zero");
endmodule

bind numeric_hash_mersenne61 nhm_chk u_nhm_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_op         (i_op),
    .i_int_value  (i_int_value),
    .o_valid      (o_valid),
    .o_hash_value (o_hash_value)
);
`default_nettype wire

@@ bench/tb_top.sv @@
// self-checking testbench for the mersenne-61 numeric hash
`timescale 1ns / 1ps
module tb_top;

    localparam nhm_pkg::t_word PRIME    = 64'h1FFF_FFFF_FFFF_FFFF;
    localparam nhm_pkg::t_word INT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int             N_WORDS  = 1550;

    typedef struct {
        nhm_pkg::t_word want;
        logic           op;
        nhm_pkg::t_word operand;
    } t_pending_hash;

    // holds the hashes still owed by the block and checks each one as it appears
    class t_hash_tracker;
        t_pending_hash pending[$];
        int mismatch_count = 0;

        function nhm_pkg::t_word dodge_minus_one(nhm_pkg::t_word h);
            return (h == nhm_pkg::MINUS_ONE) ? nhm_pkg::MINUS_TWO : h;
        endfunction

        function nhm_pkg::t_word int_hash(nhm_pkg::t_word raw);
            nhm_pkg::t_word mag;
            nhm_pkg::t_word h;
            if (raw == nhm_pkg::MIN_INT) return nhm_pkg::MIN_INT_HASH;
            mag = raw[63] ? (64'd0 - raw) : raw;
            h = mag % PRIME;
            if (raw[63]) h = 64'd0 - h;
            return dodge_minus_one(h);
        endfunction

        function nhm_pkg::t_word float_hash(nhm_pkg::t_word bits, nhm_pkg::t_word addr);
            logic [10:0] expo;
            logic [51:0] frac;
            nhm_pkg::t_word mant;
            nhm_pkg::t_word h;
            int e;
            int k;
            expo = bits[62:52];
            frac = bits[51:0];
            if (expo == nhm_pkg::EXP_SPECIAL) begin
                if (frac == 52'd0)
                    return bits[63] ? (64'd0 - nhm_pkg::INF_HASH) : nhm_pkg::INF_HASH;
                // nan hashes by identity
                return dodge_minus_one({addr[3:0], addr[63:4]});
            end
            if (expo == nhm_pkg::EXP_ZERO) begin
                if (frac == 52'd0) return 64'd0;
                mant = {12'd0, frac};
                e = -1074;
            end else begin
                mant = {11'd0, 1'b1, frac};
                e = int'(expo) - 1075;
            end
            // multiplying by 2^e mod p is a rotation within 61 bits
            k = ((e % 61) + 61) % 61;
            h = mant;
            if (k != 0) h = ((h << k) & PRIME) | (h >> (61 - k));
            if (bits[63]) h = 64'd0 - h;
            return dodge_minus_one(h);
        endfunction

        function void note_word(logic op, nhm_pkg::t_word iv, nhm_pkg::t_word fb,
                                nhm_pkg::t_word addr);
            t_pending_hash p;
            p.op = op;
            p.operand = (op == nhm_pkg::OP_INT) ? iv : fb;
            p.want = (op == nhm_pkg::OP_INT) ? int_hash(iv) : float_hash(fb, addr);
            pending.push_back(p);
        endfunction

        task flag_mismatch(string msg);
            mismatch_count++;
            $display("mismatch: %s", msg);
        endtask

        task check_hash(nhm_pkg::t_word got);
            t_pending_hash p;
            if (pending.size() == 0) begin
                flag_mismatch($sformatf("hash %h with no word pending", got));
            end else begin
                p = pending.pop_front();
                if (got !== p.want)
                    flag_mismatch($sformatf("op %0d operand %h: hash %h, want %h",
                                            p.op, p.operand, got, p.want));
            end
        endtask

        task close_out();
            if (pending.size() != 0)
                flag_mismatch($sformatf("%0d hashes never appeared", pending.size()));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_op;
    logic signed [63:0]  i_int_value;
    logic [63:0]         i_float_bits;
    logic [63:0]         i_object_address;
    logic                o_valid;
    logic signed [63:0]  o_hash_value;

    t_hash_tracker tracker = new();

    numeric_hash_mersenne61 i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_int_value      (i_int_value),
        .i_float_bits     (i_float_bits),
        .i_object_address (i_object_address),
        .o_valid          (o_valid),
        .o_hash_value     (o_hash_value)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (o_valid === 1'b1) tracker.check_hash(o_hash_value);
    end

    function nhm_pkg::t_word rnd64();
        return {$urandom, $urandom};
    endfunction

    // integers biased towards the interesting spots: around multiples of p,
    // around the range ends and powers of two
    function nhm_pkg::t_word pick_int();
        nhm_pkg::t_word v;
        case ($urandom_range(0, 4))
            0: v = rnd64();
            1: v = nhm_pkg::t_word'($urandom_range(0, 600)) - 64'd300;
            2: v = PRIME * $urandom_range(0, 4) + $urandom_range(0, 6) - 64'd3;
            3: v = $urandom_range(0, 1) ? nhm_pkg::MIN_INT + $urandom_range(0, 4)
                                        : INT_MAX - $urandom_range(0, 4);
            default: v = (64'd1 << $urandom_range(0, 63)) + $urandom_range(0, 2) - 64'd1;
        endcase
        if ($urandom_range(0, 1) && (v != nhm_pkg::MIN_INT)) v = 64'd0 - v;
        return v;
    endfunction

    function nhm_pkg::t_word pick_float();
        logic        sign;
        logic [10:0] expo;
        logic [51:0] frac;
        sign = 1'($urandom_range(0, 1));
        frac = 52'(rnd64());
        case ($urandom_range(0, 9))
            0: begin
                expo = nhm_pkg::EXP_ZERO;
                frac = 52'd0;
            end
            1: begin
                expo = nhm_pkg::EXP_SPECIAL;
                frac = 52'd0;
            end
            2: begin
                expo = nhm_pkg::EXP_SPECIAL;
                if (frac == 52'd0) frac = 52'd1;
            end
            3: expo = nhm_pkg::EXP_ZERO;
            // around the exponent where the rotation is zero
            4: expo = 11'd1075 + 11'($urandom_range(0, 8)) - 11'd4;
            5: return rnd64();
            default: expo = 11'($urandom_range(1, 2046));
        endcase
        return {sign, expo, frac};
    endfunction

    task send_word(logic op, nhm_pkg::t_word iv, nhm_pkg::t_word fb, nhm_pkg::t_word addr);
        @(negedge i_clk);
        start            <= 1'b1;
        i_op             <= op;
        i_int_value      <= iv;
        i_float_bits     <= fb;
        i_object_address <= addr;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_word(op, iv, fb, addr);
    endtask

    // idle cycles carry junk on the fields to show they are ignored
    task hold_off(int n);
        repeat (n) begin
            @(negedge i_clk);
            start            <= 1'b0;
            i_op             <= 1'($urandom_range(0, 1));
            i_int_value      <= rnd64();
            i_float_bits     <= rnd64();
            i_object_address <= rnd64();
        end
    endtask

    task send_int(nhm_pkg::t_word v);
        send_word(nhm_pkg::OP_INT, v, rnd64(), rnd64());
    endtask

    task send_float(nhm_pkg::t_word bits, nhm_pkg::t_word addr);
        send_word(nhm_pkg::OP_FLOAT, rnd64(), bits, addr);
    endtask

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int words_sent;
        int burst;
        int gap;
        int waited;

        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_op             = nhm_pkg::OP_INT;
        i_int_value      = 64'd0;
        i_float_bits     = 64'd0;
        i_object_address = 64'd0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words, back to back
        send_int(64'd0);
        send_int(64'd1);
        send_int(nhm_pkg::MINUS_ONE);
        send_int(nhm_pkg::MINUS_TWO);
        send_int(INT_MAX);
        send_int(nhm_pkg::MIN_INT);
        send_int(PRIME);
        send_int(PRIME - 64'd1);
        send_int(PRIME + 64'd1);
        send_int(64'd0 - PRIME);
        send_float(64'h0000_0000_0000_0000, rnd64());
        send_float(64'h8000_0000_0000_0000, rnd64());
        send_float(64'h7FF0_0000_0000_0000, rnd64());
        send_float(64'hFFF0_0000_0000_0000, rnd64());
        send_float(64'h7FF8_0000_0000_0000, rnd64());
        // signalling nan whose rotated address would be minus one
        send_float(64'hFFF0_0000_0000_0001, nhm_pkg::MINUS_ONE);
        send_float(64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
        send_float(64'h3FF0_0000_0000_0000, rnd64());
        send_float(64'hBFF0_0000_0000_0000, rnd64());
        send_float(64'h0000_0000_0000_0001, rnd64());
        send_float(64'h800F_FFFF_FFFF_FFFF, rnd64());
        send_float(64'h0010_0000_0000_0000, rnd64());
        send_float(64'h7FEF_FFFF_FFFF_FFFF, rnd64());
        send_float(64'h4330_0000_0000_0000, rnd64());
        send_float(64'hC330_0000_0000_0001, rnd64());
        words_sent = 25;
        hold_off(3);

        while (words_sent < N_WORDS) begin
            burst = $urandom_range(1, 32);
            for (int i = 0; i < burst && words_sent < N_WORDS; i++) begin
                if ($urandom_range(0, 1)) send_int(pick_int());
                else send_float(pick_float(), rnd64());
                words_sent++;
            end
            if ($urandom_range(0, 3) == 0) gap = 0;
            else if ($urandom_range(0, 9) == 0) gap = $urandom_range(7, 20);
            else gap = $urandom_range(1, 6);
            hold_off(gap);
        end
        hold_off(1);

        waited = 0;
        while (tracker.pending.size() != 0 && waited < 200) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        tracker.close_out();

        if (tracker.mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
